FILE: rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character map of the Base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned ResMax = 3;   // results one character can cause

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_LEN  = 2'd2
    } status_t;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;   // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;   // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;   // '/'
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;
    localparam logic [5:0] LOWER_BASE   = 6'd26;
    localparam logic [5:0] DIGIT_BASE   = 6'd52;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        status_t    status;
        logic       final_res;
    } result_t;

    // all results caused by one character, res[0] leaves first
    typedef struct packed {
        result_t [ResMax-1:0] res;
        logic    [1:0]        n;
    } record_t;

    typedef struct packed {
        logic [1:0]  pos;
        logic [17:0] acc;
        logic        pad;
        logic        err;
    } dec_state_t;

    function automatic result_t make_res(logic [7:0] b, logic present, status_t st,
                                         logic fin);
        result_t r;
        r.data_byte    = b;
        r.byte_present = present;
        r.status       = st;
        r.final_res    = fin;
        return r;
    endfunction

    // {valid, sextet}
    function automatic logic [6:0] sextet_of(logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61) + LOWER_BASE};
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30) + DIGIT_BASE};
        end
        else if (c == CHAR_PLUS) begin
            r = {1'b1, SEXTET_PLUS};
        end
        else if (c == CHAR_SLASH) begin
            r = {1'b1, SEXTET_SLASH};
        end
        return r;
    endfunction

endpackage

FILE: rtl/b64d_decode.sv
// ----------------------------------------------------------------------------
// b64d_decode
// Next-state and result record for one character, given the quartet state.
// ----------------------------------------------------------------------------
module b64d_decode (
    input  b64d_pkg::dec_state_t st,
    input  logic [7:0]           char_code,
    input  logic                 end_of_text,
    output b64d_pkg::dec_state_t st_next,
    output b64d_pkg::record_t    rec
);
    import b64d_pkg::*;

    logic [6:0]  sx;
    logic [1:0]  pos_next;
    logic [23:0] triple;

    assign sx       = sextet_of(char_code);
    assign pos_next = st.pos + 2'd1;
    assign triple   = {st.acc, sx[5:0]};

    always_comb
    begin
        st_next = st;
        rec     = '0;
        if (st.err) begin
            if (end_of_text) begin
                st_next = '0;
            end
        end
        else if (st.pad) begin
            if (end_of_text) begin
                rec.res[0] = make_res(8'd0, 1'b0,
                                      (pos_next == 2'd0) ? ST_OK : ST_BAD_LEN, 1'b1);
                rec.n      = 2'd1;
                st_next    = '0;
            end
            else begin
                st_next.pos = pos_next;
            end
        end
        else if (char_code == CHAR_PAD && st.pos >= 2'd2) begin
            if (st.pos == 2'd2) begin
                rec.res[0] = make_res(st.acc[11:4], 1'b1, ST_OK, 1'b0);
                rec.n      = 2'd1;
                if (end_of_text) begin
                    rec.res[1] = make_res(8'd0, 1'b0, ST_BAD_LEN, 1'b1);
                    rec.n      = 2'd2;
                end
            end
            else begin
                rec.res[0] = make_res(st.acc[17:10], 1'b1, ST_OK, 1'b0);
                rec.res[1] = make_res(st.acc[9:2], 1'b1, ST_OK, end_of_text);
                rec.n      = 2'd2;
            end
            if (end_of_text) begin
                st_next = '0;
            end
            else begin
                st_next.pad = 1'b1;
                st_next.pos = pos_next;
                st_next.acc = '0;
            end
        end
        else if (char_code == CHAR_PAD || !sx[6]) begin
            // bad character, or padding too early in the quartet
            rec.res[0] = make_res(8'd0, 1'b0, ST_BAD_CHAR, 1'b1);
            rec.n      = 2'd1;
            if (end_of_text) begin
                st_next = '0;
            end
            else begin
                st_next.err = 1'b1;
            end
        end
        else if (st.pos != 2'd3) begin
            st_next.acc = {st.acc[11:0], sx[5:0]};
            st_next.pos = pos_next;
            if (end_of_text) begin
                rec.res[0] = make_res(8'd0, 1'b0, ST_BAD_LEN, 1'b1);
                rec.n      = 2'd1;
                st_next    = '0;
            end
        end
        else begin
            rec.res[0] = make_res(triple[23:16], 1'b1, ST_OK, 1'b0);
            rec.res[1] = make_res(triple[15:8], 1'b1, ST_OK, 1'b0);
            rec.res[2] = make_res(triple[7:0], 1'b1, ST_OK, end_of_text);
            rec.n      = 2'd3;
            st_next    = '0;
        end
    end

endmodule

FILE: rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming Base64 decoder, one character per cycle while char_ready is high.
// Input channel (char_valid/char_ready): char_code plus end_of_text on the
// last character of a string. Output channel (res_valid/res_ready): one
// result per transfer, either a decoded byte or a status-only result;
// final_res marks the last result of the string.
// The first result of a character is registered into the head slot, or into
// the spare slot while the head still drains. A full quartet yields three
// bytes that drain one per cycle while res_ready is high and the next
// characters are taken. Each character's results are held as one record;
// two record slots (head and spare) decouple the sides, so char_ready
// drops only while both slots are occupied.
// Reset clears the quartet state and empties both slots. On a receiver stall,
// the head result holds steady and the spare slot absorbs one more record.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  logic [7:0] char_code,
    input  logic       end_of_text,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] data_byte,
    output logic       byte_present,
    output logic [1:0] status,
    output logic       final_res
);
    import b64d_pkg::*;

    dec_state_t state_reg, state_next;
    dec_state_t dec_state;
    record_t    dec_rec;

    record_t    head_reg, head_next;
    record_t    spare_reg, spare_next;
    logic       head_valid_reg, head_valid_next;
    logic       spare_valid_reg, spare_valid_next;
    logic [1:0] idx_reg, idx_next;

    logic    char_xfer;
    logic    push;
    logic    res_xfer;
    logic    head_done;
    result_t head_res;

    b64d_decode u_decode (
        .st          (state_reg),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .st_next     (dec_state),
        .rec         (dec_rec)
    );

    // spare slot free means a new record always has somewhere to go
    assign char_ready = !spare_valid_reg;
    assign char_xfer  = char_valid && char_ready;
    assign push       = char_xfer && (dec_rec.n != 2'd0);

    assign head_res     = head_reg.res[idx_reg];
    assign res_valid    = head_valid_reg;
    assign data_byte    = head_res.data_byte;
    assign byte_present = head_res.byte_present;
    assign status       = head_res.status;
    assign final_res    = head_res.final_res;

    assign res_xfer  = res_valid && res_ready;
    assign head_done = res_xfer && (idx_reg == head_reg.n - 2'd1);

    always_comb
    begin
        state_next       = char_xfer ? dec_state : state_reg;
        head_next        = head_reg;
        spare_next       = spare_reg;
        head_valid_next  = head_valid_reg;
        spare_valid_next = spare_valid_reg;
        idx_next         = res_xfer ? idx_reg + 2'd1 : idx_reg;

        if (head_valid_reg && !head_done) begin
            // head still draining: a new record waits in the spare slot
            if (push) begin
                spare_next       = dec_rec;
                spare_valid_next = 1'b1;
            end
        end
        else if (spare_valid_reg) begin
            head_next        = spare_reg;
            head_valid_next  = 1'b1;
            idx_next         = 2'd0;
            spare_next       = dec_rec;
            spare_valid_next = push;
        end
        else begin
            head_next       = dec_rec;
            head_valid_next = push;
            idx_next        = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= '0;
            head_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
            idx_reg         <= 2'd0;
        end
        else begin
            state_reg       <= state_next;
            head_valid_reg  <= head_valid_next;
            spare_valid_reg <= spare_valid_next;
            idx_reg         <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

`ifndef SYNTHESIS
    // spare slot is only filled behind a live head
    assert property (@(posedge clk) disable iff (!rst_n)
        spare_valid_reg |-> head_valid_reg)
        else $error("spare record without head record");

    // read index stays inside the head record
    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid_reg |-> (head_reg.n != 2'd0 && idx_reg < head_reg.n))
        else $error("head index outside record");

    // end of string returns the quartet state to its idle value
    assert property (@(posedge clk) disable iff (!rst_n)
        (char_xfer && end_of_text) |=> (state_reg == '0))
        else $error("state not cleared after end of string");

    // after an error nothing is emitted until the string ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (char_xfer && state_reg.err) |-> !push)
        else $error("result produced after latched error");

    // a final result is always the last one of its record
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && final_res) |-> (idx_reg == head_reg.n - 2'd1))
        else $error("final result not last in record");
`endif

endmodule
